// ===== hdl/mvwm_pkg.sv =====
package mvwm_pkg;

   localparam int WIN_LEN = 6;
   localparam int FILL_W = 3;
   localparam logic [FILL_W-1:0] FILL_FULL = 3'd6;

   // 999999 cm^2 * 36 * 64^2
   localparam int LIMIT_W = 38;
   localparam logic [LIMIT_W-1:0] SCORE_LIMIT = 38'd147455852544;

   typedef struct packed {
      logic valid;
      logic last;
      logic full;
   } mvwm_ctl_type;

endpackage

// ===== hdl/mvwm_req_if.sv =====
interface mvwm_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;
   logic                   last;

   modport source (output valid, output sample, output last, input ready);
   modport sink   (input valid, input sample, input last, output ready);
endinterface

// ===== hdl/mvwm_rsp_if.sv =====
interface mvwm_rsp_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] best_mean;
   logic                   valid_res;

   modport source (output valid, output best_mean, output valid_res, input ready);
   modport sink   (input valid, input best_mean, input valid_res, output ready);
endinterface

// ===== hdl/min_variance_window_mean_unit.sv =====
// Minimum-variance window mean. Takes one distance sample per cycle (1/64 cm units); over
// each block it slides a six-sample window, scores every full window as
// 6*sum(x^2) - sum(x)^2 and keeps the floored mean of the lowest-scoring one
// (earlier window wins a tie, scores must lie under the 999999 cm^2 limit). The sample
// marked last produces one result transaction once it leaves the result register; other
// samples produce none. The unit is a four-stage pipeline (input register, running
// sums, square and divide-by-six, best select and result register) that advances as a
// whole, so it takes a sample every cycle and stalls only while a result is held
// unread on the response channel. valid_res is 0 for blocks shorter than six samples.
module min_variance_window_mean_unit #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   mvwm_req_if.sink   req,
   mvwm_rsp_if.source rsp
);
   logic                        advance;
   mvwm_pkg::mvwm_ctl_type      ctl1_ff;
   logic [SAMPLE_BITS-1:0]      sample_ff;
   mvwm_pkg::mvwm_ctl_type      ctl2;
   logic [SAMPLE_BITS+2:0]      sum2;
   logic [2*SAMPLE_BITS+2:0]    sqsum2;
   mvwm_pkg::mvwm_ctl_type      ctl3;
   logic [2*SAMPLE_BITS+5:0]    six_sq3;
   logic [2*SAMPLE_BITS+5:0]    sum_sq3;
   logic [SAMPLE_BITS-1:0]      mean3;
   logic                        rsp_valid_w;

   assign advance   = !rsp_valid_w || rsp.ready;
   assign req.ready = advance;
   assign rsp.valid = rsp_valid_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
      end else if (advance) begin
         ctl1_ff.valid <= req.valid;
         ctl1_ff.last  <= req.last;
         ctl1_ff.full  <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sample_ff <= req.sample;
      end
   end

   mvwm_window #(.SAMPLE_BITS(SAMPLE_BITS)) u_window (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .ctl_in    (ctl1_ff),
      .sample_in (sample_ff),
      .ctl_out   (ctl2),
      .sum_out   (sum2),
      .sqsum_out (sqsum2)
   );

   mvwm_score #(.SAMPLE_BITS(SAMPLE_BITS)) u_score (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .ctl_in     (ctl2),
      .sum_in     (sum2),
      .sqsum_in   (sqsum2),
      .ctl_out    (ctl3),
      .six_sq_out (six_sq3),
      .sum_sq_out (sum_sq3),
      .mean_out   (mean3)
   );

   mvwm_select #(.SAMPLE_BITS(SAMPLE_BITS)) u_select (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .ctl_in        (ctl3),
      .six_sq_in     (six_sq3),
      .sum_sq_in     (sum_sq3),
      .mean_in       (mean3),
      .rsp_valid     (rsp_valid_w),
      .rsp_best_mean (rsp.best_mean),
      .rsp_valid_res (rsp.valid_res)
   );

endmodule

// ===== hdl/mvwm_window.sv =====
module mvwm_window #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  mvwm_pkg::mvwm_ctl_type      ctl_in,
   input  logic [SAMPLE_BITS-1:0]      sample_in,
   output mvwm_pkg::mvwm_ctl_type      ctl_out,
   output logic [SAMPLE_BITS+2:0]      sum_out,
   output logic [2*SAMPLE_BITS+2:0]    sqsum_out
);
   localparam int SUM_W = SAMPLE_BITS + 3;
   localparam int SQ_W = 2 * SAMPLE_BITS;
   localparam int SQSUM_W = 2 * SAMPLE_BITS + 3;
   localparam int N = mvwm_pkg::WIN_LEN;

   logic [SAMPLE_BITS-1:0]          win_ff [N];
   logic [SQ_W-1:0]                 winsq_ff [N];
   logic [SUM_W-1:0]                sum_ff;
   logic [SQSUM_W-1:0]              sqsum_ff;
   logic [mvwm_pkg::FILL_W-1:0]     fill_ff;

   logic [SQ_W-1:0]                 sq_new;
   logic [SUM_W-1:0]                sum_in;
   logic [SQSUM_W-1:0]              sqsum_in;
   logic [mvwm_pkg::FILL_W-1:0]     fill_in;

   mvwm_pkg::mvwm_ctl_type          ctl_ff;
   logic [SUM_W-1:0]                sum_out_ff;
   logic [SQSUM_W-1:0]              sqsum_out_ff;

   assign sq_new   = SQ_W'(sample_in) * SQ_W'(sample_in);
   assign sum_in   = sum_ff + SUM_W'(sample_in) - SUM_W'(win_ff[0]);
   assign sqsum_in = sqsum_ff + SQSUM_W'(sq_new) - SQSUM_W'(winsq_ff[0]);
   assign fill_in  = (fill_ff == mvwm_pkg::FILL_FULL) ? fill_ff : fill_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < N; k++) begin
            win_ff[k]   <= '0;
            winsq_ff[k] <= '0;
         end
         sum_ff   <= '0;
         sqsum_ff <= '0;
         fill_ff  <= '0;
      end else if (advance && ctl_in.valid) begin
         if (ctl_in.last) begin
            for (int k = 0; k < N; k++) begin
               win_ff[k]   <= '0;
               winsq_ff[k] <= '0;
            end
            sum_ff   <= '0;
            sqsum_ff <= '0;
            fill_ff  <= '0;
         end else begin
            for (int k = 0; k < N - 1; k++) begin
               win_ff[k]   <= win_ff[k+1];
               winsq_ff[k] <= winsq_ff[k+1];
            end
            win_ff[N-1]   <= sample_in;
            winsq_ff[N-1] <= sq_new;
            sum_ff   <= sum_in;
            sqsum_ff <= sqsum_in;
            fill_ff  <= fill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff.valid <= ctl_in.valid;
         ctl_ff.last  <= ctl_in.last;
         ctl_ff.full  <= (fill_in == mvwm_pkg::FILL_FULL);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sum_out_ff   <= sum_in;
         sqsum_out_ff <= sqsum_in;
      end
   end

   assign ctl_out   = ctl_ff;
   assign sum_out   = sum_out_ff;
   assign sqsum_out = sqsum_out_ff;

endmodule

// ===== hdl/mvwm_score.sv =====
module mvwm_score #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  mvwm_pkg::mvwm_ctl_type      ctl_in,
   input  logic [SAMPLE_BITS+2:0]      sum_in,
   input  logic [2*SAMPLE_BITS+2:0]    sqsum_in,
   output mvwm_pkg::mvwm_ctl_type      ctl_out,
   output logic [2*SAMPLE_BITS+5:0]    six_sq_out,
   output logic [2*SAMPLE_BITS+5:0]    sum_sq_out,
   output logic [SAMPLE_BITS-1:0]      mean_out
);
   localparam int SUM_W = SAMPLE_BITS + 3;
   localparam int SCORE_W = 2 * SAMPLE_BITS + 6;
   // floor(s / 6) = (s * ceil(2^K / 6)) >> K for all s below 2^SUM_W
   localparam int DIV_K = SUM_W + 3;
   localparam int PROD_W = SUM_W + DIV_K;
   localparam logic [DIV_K-1:0] DIV_M =
      DIV_K'(((64'd1 << DIV_K) + 64'd5) / 64'd6);

   logic [SCORE_W-1:0]     six_sq;
   logic [SCORE_W-1:0]     sum_sq;
   logic [PROD_W-1:0]      recip_prod;

   mvwm_pkg::mvwm_ctl_type ctl_ff;
   logic [SCORE_W-1:0]     six_sq_ff;
   logic [SCORE_W-1:0]     sum_sq_ff;
   logic [SAMPLE_BITS-1:0] mean_ff;

   assign six_sq     = (SCORE_W'(sqsum_in) << 2) + (SCORE_W'(sqsum_in) << 1);
   assign sum_sq     = SCORE_W'(sum_in) * SCORE_W'(sum_in);
   assign recip_prod = PROD_W'(sum_in) * PROD_W'(DIV_M);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         six_sq_ff <= six_sq;
         sum_sq_ff <= sum_sq;
         mean_ff   <= recip_prod[DIV_K +: SAMPLE_BITS];
      end
   end

   assign ctl_out    = ctl_ff;
   assign six_sq_out = six_sq_ff;
   assign sum_sq_out = sum_sq_ff;
   assign mean_out   = mean_ff;

endmodule

// ===== hdl/mvwm_select.sv =====
module mvwm_select #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  mvwm_pkg::mvwm_ctl_type      ctl_in,
   input  logic [2*SAMPLE_BITS+5:0]    six_sq_in,
   input  logic [2*SAMPLE_BITS+5:0]    sum_sq_in,
   input  logic [SAMPLE_BITS-1:0]      mean_in,
   output logic                        rsp_valid,
   output logic [SAMPLE_BITS-1:0]      rsp_best_mean,
   output logic                        rsp_valid_res
);
   localparam int SCORE_W = 2 * SAMPLE_BITS + 6;
   localparam int BEST_W = (SCORE_W > mvwm_pkg::LIMIT_W) ? SCORE_W : mvwm_pkg::LIMIT_W;

   logic [SCORE_W-1:0]     score;
   logic                   take;
   logic [BEST_W-1:0]      best_score_ff;
   logic [SAMPLE_BITS-1:0] best_value_ff;
   logic [BEST_W-1:0]      best_score_in;
   logic [SAMPLE_BITS-1:0] best_value_in;

   logic                   valid_ff;
   logic [SAMPLE_BITS-1:0] mean_ff;
   logic                   valid_res_ff;

   assign score = six_sq_in - sum_sq_in;
   assign take  = ctl_in.full && (BEST_W'(score) < best_score_ff);
   assign best_score_in = take ? BEST_W'(score) : best_score_ff;
   assign best_value_in = take ? mean_in : best_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         best_score_ff <= BEST_W'(mvwm_pkg::SCORE_LIMIT);
         best_value_ff <= '0;
      end else if (advance && ctl_in.valid) begin
         if (ctl_in.last) begin
            best_score_ff <= BEST_W'(mvwm_pkg::SCORE_LIMIT);
            best_value_ff <= '0;
         end else begin
            best_score_ff <= best_score_in;
            best_value_ff <= best_value_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= ctl_in.valid && ctl_in.last;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mean_ff      <= ctl_in.full ? best_value_in : '0;
         valid_res_ff <= ctl_in.full;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_best_mean = mean_ff;
   assign rsp_valid_res = valid_res_ff;

endmodule

// ===== hdl/mvwm_checker.sv =====
module mvwm_checker #(
   parameter int SAMPLE_BITS = 16
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [SAMPLE_BITS-1:0] rsp_best_mean,
   input logic                   rsp_valid_res
);

   // a held result transaction keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_best_mean)
                                  && $stable(rsp_valid_res))
      else $error("response changed while stalled");

   // input is only throttled by an unread result
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

   // a short block reports zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> rsp_best_mean == '0)
      else $error("short block with nonzero mean");

   // no response right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response out of reset");

endmodule

bind min_variance_window_mean_unit mvwm_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_best_mean (rsp.best_mean),
   .rsp_valid_res (rsp.valid_res)
);
